[hdl/lce_pkg.sv]
// ----------------------------------------------------------------------------
// lce_pkg: shared types and constants for the LED chain frame buffer encoder
// Holds the command codes, the job record passed from front to back, the
// palette reset values and the serial bit encoding function.
// ----------------------------------------------------------------------------
`default_nettype none

package lce_pkg;

  localparam int NUM_PAL   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 24;
  localparam int CHAIN_AW  = 7;
  localparam int SEND_MAX  = 64;
  localparam int QDEPTH    = 2;

  // palette index that means off
  localparam logic [7:0] COLOR_OFF = 8'd7;

  // group codes
  localparam logic [2:0] GRP_A = 3'd0;
  localparam logic [2:0] GRP_B = 3'd1;
  localparam logic [2:0] GRP_C = 3'd2;
  localparam logic [2:0] GRP_D = 3'd3;

  // serial nibbles for a one bit and a zero bit
  localparam logic [3:0] NIB_ONE  = 4'hE;
  localparam logic [3:0] NIB_ZERO = 4'h8;

  // palette reset, packed green red blue
  localparam logic [COLOR_W-1:0] PAL_RESET [NUM_PAL] = '{
    24'h000600, 24'h020400, 24'h030300, 24'h060000,
    24'h040002, 24'h000006, 24'h000303
  };

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_FILL = 2'd1,
    ACT_SEND = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_SEND
  } bk_state_t;

  // one classified command: optional write sweep, optional chain send
  typedef struct packed {
    logic                wr;
    logic                send;
    logic                chain;
    logic [CHAIN_AW-1:0] base;
    logic [CHAIN_AW-1:0] count;
    logic [COLOR_W-1:0]  color;
  } job_t;

  // two color bits per serial byte, msb first
  function automatic logic [31:0] enc_byte(input logic [7:0] b);
    logic [31:0] code;
    code = '0;
    for (int k = 0; k < 4; k++) begin
      code[31-8*k -: 4] = b[7-2*k] ? NIB_ONE : NIB_ZERO;
      code[27-8*k -: 4] = b[6-2*k] ? NIB_ONE : NIB_ZERO;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

[hdl/lce_if.sv]
// ----------------------------------------------------------------------------
// lce_if: channel interfaces of the LED chain frame buffer encoder
// Command channel, LED word channel and configuration write channel, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lce_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] group;
  logic [5:0] position;
  logic [7:0] color_choice;
  logic       chain_select;

  modport source (output valid, action, group, position, color_choice, chain_select,
                  input ready);
  modport sink (input valid, action, group, position, color_choice, chain_select,
                output ready);
endinterface

interface lce_led_if;
  logic        valid;
  logic        ready;
  logic        chain_id;
  logic [5:0]  led_number;
  logic [31:0] green_code;
  logic [31:0] red_code;
  logic [31:0] blue_code;
  logic        last_led;

  modport source (output valid, chain_id, led_number, green_code, red_code, blue_code,
                  last_led, input ready);
  modport sink (input valid, chain_id, led_number, green_code, red_code, blue_code,
                last_led, output ready);
endinterface

interface lce_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/lce_front.sv]
// ----------------------------------------------------------------------------
// lce_front: command intake and classification
// Holds the palette registers, resolves the color, checks group and position
// and turns each useful command into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_front #(
  parameter int GROUP_A_COUNT = 28,
  parameter int GROUP_B_COUNT = 7,
  parameter int GROUP_C_COUNT = 28,
  parameter int GROUP_D_COUNT = 26
) (
  input  wire logic        clk,
  input  wire logic        rst,
  lce_cmd_if.sink          cmd,
  lce_cfg_if.sink          cfg,
  input  wire logic        q_full,
  output logic             push,
  output lce_pkg::job_t    push_data
);

  logic [lce_pkg::COLOR_W-1:0]  palette [lce_pkg::NUM_PAL];
  logic [lce_pkg::COLOR_W-1:0]  color;
  logic [lce_pkg::CHAIN_AW-1:0] pos7;
  logic                         keep;

  // palette registers, ready once out of reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lce_pkg::NUM_PAL; i++) begin
        palette[i] <= lce_pkg::PAL_RESET[i];
      end
    end else if (cfg.valid && cfg.index < lce_pkg::CFG_IDX_W'(lce_pkg::NUM_PAL)) begin
      palette[cfg.index] <= cfg.data;
    end
  end

  // color lookup: off, palette entry, or red for anything above
  always_comb begin
    priority if (cmd.color_choice == lce_pkg::COLOR_OFF) begin
      color = '0;
    end else if (cmd.color_choice < lce_pkg::COLOR_OFF) begin
      color = palette[cmd.color_choice[2:0]];
    end else begin
      color = palette[0];
    end
  end

  // classify the command
  always_comb begin
    keep      = 1'b0;
    push_data = '0;
    push_data.color = color;
    pos7      = {1'b0, cmd.position};
    unique case (cmd.action)
      lce_pkg::ACT_SET: begin
        push_data.wr    = 1'b1;
        push_data.count = lce_pkg::CHAIN_AW'(1);
        priority if (cmd.group == lce_pkg::GRP_A
                     && pos7 < lce_pkg::CHAIN_AW'(GROUP_A_COUNT)) begin
          keep           = 1'b1;
          push_data.base = pos7;
        end else if (cmd.group == lce_pkg::GRP_B
                     && pos7 < lce_pkg::CHAIN_AW'(GROUP_B_COUNT)) begin
          keep           = 1'b1;
          push_data.base = lce_pkg::CHAIN_AW'(GROUP_A_COUNT) + pos7;
        end else if (cmd.group == lce_pkg::GRP_C
                     && pos7 < lce_pkg::CHAIN_AW'(GROUP_C_COUNT)) begin
          keep            = 1'b1;
          push_data.chain = 1'b1;
          push_data.base  = pos7;
        end else if (cmd.group == lce_pkg::GRP_D
                     && pos7 < lce_pkg::CHAIN_AW'(GROUP_D_COUNT)) begin
          keep            = 1'b1;
          push_data.chain = 1'b1;
          push_data.base  = lce_pkg::CHAIN_AW'(GROUP_C_COUNT) + pos7;
        end else begin
          keep = 1'b0;
        end
      end
      lce_pkg::ACT_FILL: begin
        push_data.wr   = 1'b1;
        push_data.send = 1'b1;
        priority if (cmd.group == lce_pkg::GRP_A) begin
          keep            = 1'b1;
          push_data.count = lce_pkg::CHAIN_AW'(GROUP_A_COUNT);
        end else if (cmd.group == lce_pkg::GRP_B) begin
          keep            = 1'b1;
          push_data.base  = lce_pkg::CHAIN_AW'(GROUP_A_COUNT);
          push_data.count = lce_pkg::CHAIN_AW'(GROUP_B_COUNT);
        end else if (cmd.group == lce_pkg::GRP_C) begin
          keep            = 1'b1;
          push_data.chain = 1'b1;
          push_data.count = lce_pkg::CHAIN_AW'(GROUP_C_COUNT);
        end else if (cmd.group == lce_pkg::GRP_D) begin
          keep            = 1'b1;
          push_data.chain = 1'b1;
          push_data.base  = lce_pkg::CHAIN_AW'(GROUP_C_COUNT);
          push_data.count = lce_pkg::CHAIN_AW'(GROUP_D_COUNT);
        end else begin
          keep = 1'b0;
        end
      end
      lce_pkg::ACT_SEND: begin
        keep            = 1'b1;
        push_data.send  = 1'b1;
        push_data.chain = cmd.chain_select;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped commands are still taken, nothing is taken during reset
  assign cmd.ready = !q_full && !rst;
  assign push      = cmd.valid && !q_full && !rst && keep;

endmodule

`default_nettype wire

[hdl/lce_queue.sv]
// ----------------------------------------------------------------------------
// lce_queue: short job queue between front and back
// Small FIFO of classified jobs so the front keeps taking commands while the
// back end sweeps or sends.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lce_pkg::job_t  push_data,
  output logic                full,
  output logic                q_valid,
  output lce_pkg::job_t       q_data,
  input  wire logic           pop
);

  localparam int PW = (lce_pkg::QDEPTH > 1) ? $clog2(lce_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(lce_pkg::QDEPTH + 1);

  lce_pkg::job_t   entry [lce_pkg::QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   fill;

  assign full    = (fill == CW'(lce_pkg::QDEPTH));
  assign q_valid = (fill != '0);
  assign q_data  = entry[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(lce_pkg::QDEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(lce_pkg::QDEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/lce_back.sv]
// ----------------------------------------------------------------------------
// lce_back: frame store sweeper and chain sender
// Owns the two chain color memories; writes one LED per cycle for a set or
// fill; for a fill or send, reads and encodes one LED per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_back #(
  parameter int GROUP_A_COUNT = 28,
  parameter int GROUP_B_COUNT = 7,
  parameter int GROUP_C_COUNT = 28,
  parameter int GROUP_D_COUNT = 26
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire lce_pkg::job_t  q_data,
  output logic                q_pop,
  lce_led_if.source           led
);

  localparam int FIRST_LEN   = GROUP_A_COUNT + GROUP_B_COUNT;
  localparam int SECOND_LEN  = GROUP_C_COUNT + GROUP_D_COUNT;
  localparam int F_AW        = $clog2(FIRST_LEN);
  localparam int S_AW        = $clog2(SECOND_LEN);
  localparam int FIRST_SEND  = (FIRST_LEN > lce_pkg::SEND_MAX) ? lce_pkg::SEND_MAX : FIRST_LEN;
  localparam int SECOND_SEND = (SECOND_LEN > lce_pkg::SEND_MAX) ? lce_pkg::SEND_MAX
                                                                 : SECOND_LEN;
  localparam int AW          = lce_pkg::CHAIN_AW;

  lce_pkg::bk_state_t          state;
  lce_pkg::bk_state_t          state_next;
  lce_pkg::job_t               job;
  logic [AW-1:0]               cnt;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               send_len;
  logic                        fill_done;
  logic                        send_done;
  logic                        issue;
  logic                        we;

  logic [lce_pkg::COLOR_W-1:0] mem_a [FIRST_LEN];
  logic [lce_pkg::COLOR_W-1:0] mem_b [SECOND_LEN];
  logic [FIRST_LEN-1:0]        vld_a;
  logic [SECOND_LEN-1:0]       vld_b;
  logic [lce_pkg::COLOR_W-1:0] rd_a;
  logic [lce_pkg::COLOR_W-1:0] rd_b;
  logic                        rd_vld;
  logic                        out_valid;
  logic                        out_chain;
  logic [5:0]                  out_num;
  logic                        out_last;
  logic [lce_pkg::COLOR_W-1:0] color_out;

  assign wr_addr   = job.base + cnt;
  assign send_len  = job.chain ? AW'(SECOND_SEND) : AW'(FIRST_SEND);
  assign fill_done = (cnt == job.count - AW'(1));
  assign send_done = (cnt == send_len - AW'(1));
  assign issue     = (state == lce_pkg::BK_SEND) && (!out_valid || led.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lce_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we         = 1'b0;
    unique case (state)
      lce_pkg::BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          state_next = q_data.wr ? lce_pkg::BK_FILL : lce_pkg::BK_SEND;
        end
      end
      lce_pkg::BK_FILL: begin
        we = 1'b1;
        if (fill_done) begin
          state_next = job.send ? lce_pkg::BK_SEND : lce_pkg::BK_IDLE;
        end
      end
      lce_pkg::BK_SEND: begin
        if (issue && send_done) begin
          state_next = lce_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = lce_pkg::BK_IDLE;
      end
    endcase
  end

  // job and LED counter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (q_pop) begin
      cnt <= '0;
    end else if (we) begin
      cnt <= fill_done ? '0 : cnt + AW'(1);
    end else if (issue) begin
      cnt <= cnt + AW'(1);
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
      vld_b <= '0;
    end else if (we) begin
      if (job.chain) begin
        vld_b[wr_addr[S_AW-1:0]] <= 1'b1;
      end else begin
        vld_a[wr_addr[F_AW-1:0]] <= 1'b1;
      end
    end
  end

  // first chain memory
  always_ff @(posedge clk) begin
    if (we && !job.chain) begin
      mem_a[wr_addr[F_AW-1:0]] <= job.color;
    end
    if (issue && !job.chain) begin
      rd_a <= mem_a[cnt[F_AW-1:0]];
    end
  end

  // second chain memory
  always_ff @(posedge clk) begin
    if (we && job.chain) begin
      mem_b[wr_addr[S_AW-1:0]] <= job.color;
    end
    if (issue && job.chain) begin
      rd_b <= mem_b[cnt[S_AW-1:0]];
    end
  end

  // output register, loads while empty or being drained
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_vld    <= job.chain ? vld_b[cnt[S_AW-1:0]] : vld_a[cnt[F_AW-1:0]];
      out_chain <= job.chain;
      out_num   <= cnt[5:0];
      out_last  <= send_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (led.ready) begin
      out_valid <= 1'b0;
    end
  end

  // encode the held color
  assign color_out      = !rd_vld ? '0 : (out_chain ? rd_b : rd_a);
  assign led.valid      = out_valid;
  assign led.chain_id   = out_chain;
  assign led.led_number = out_num;
  assign led.last_led   = out_last;
  assign led.green_code = lce_pkg::enc_byte(color_out[23:16]);
  assign led.red_code   = lce_pkg::enc_byte(color_out[15:8]);
  assign led.blue_code  = lce_pkg::enc_byte(color_out[7:0]);

  // checks
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    led.valid && led.last_led |->
      led.led_number == (led.chain_id ? 6'(SECOND_SEND - 1) : 6'(FIRST_SEND - 1)))
    else $error("last LED flag on wrong position");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    state == lce_pkg::BK_FILL |-> cnt < job.count)
    else $error("fill sweep ran past group");

  a_send_in_range: assert property (@(posedge clk) disable iff (rst)
    state == lce_pkg::BK_SEND |-> cnt < send_len)
    else $error("send counter ran past chain");

  a_send_ends: assert property (@(posedge clk) disable iff (rst)
    issue && send_done |=> state == lce_pkg::BK_IDLE && out_valid && led.last_led)
    else $error("send did not finish on last LED");

endmodule

`default_nettype wire

[hdl/led_chain_frame_buffer_encoder.sv]
// ----------------------------------------------------------------------------
// led_chain_frame_buffer_encoder: two-chain RGB LED frame store and encoder
// Accepts commands on cmd, writes palette entries through cfg and emits one
// encoded LED word per LED on led when a chain is sent.
//
// cmd: set one LED, fill a group and send its chain, or send a chain. Commands
//   with a bad group or position, and the unused action, are taken and dropped.
// cfg: palette writes, ready out of reset; indexes past the palette are ignored.
// led: one item per LED in chain order, last_led on the final one.
// Back end: it takes each job from the queue while idle. A set then writes
//   its one LED and goes back to idle; a fill writes every LED of the group
//   before sending. A send puts out one LED per cycle while led is ready, up
//   to 64 LEDs of a chain, each word held in an output register. The rate is
//   set by the single read port of each chain memory.
// A two-entry job queue between the command front and the back end lets
//   commands be taken while a send is still running.
// Reset clears the written flags of both chain memories at once, so every
//   LED reads as off, and restores the palette defaults; cmd and cfg are not
//   ready during reset.
// A stalled led receiver holds the current word; the back end pauses and
//   the queue then fills until cmd.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chain_frame_buffer_encoder #(
  parameter int GROUP_A_COUNT = 28,
  parameter int GROUP_B_COUNT = 7,
  parameter int GROUP_C_COUNT = 28,
  parameter int GROUP_D_COUNT = 26
) (
  input  wire logic clk,
  input  wire logic rst,
  lce_cmd_if.sink   cmd,
  lce_cfg_if.sink   cfg,
  lce_led_if.source led
);

  logic          push;
  logic          full;
  logic          q_valid;
  logic          q_pop;
  lce_pkg::job_t push_data;
  lce_pkg::job_t q_data;

  // command intake
  lce_front #(
    .GROUP_A_COUNT(GROUP_A_COUNT),
    .GROUP_B_COUNT(GROUP_B_COUNT),
    .GROUP_C_COUNT(GROUP_C_COUNT),
    .GROUP_D_COUNT(GROUP_D_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  // job queue
  lce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  // frame store and sender
  lce_back #(
    .GROUP_A_COUNT(GROUP_A_COUNT),
    .GROUP_B_COUNT(GROUP_B_COUNT),
    .GROUP_C_COUNT(GROUP_C_COUNT),
    .GROUP_D_COUNT(GROUP_D_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .led     (led)
  );

endmodule

`default_nettype wire

[tb/led_chain_frame_buffer_encoder_tb.sv]
// ----------------------------------------------------------------------------
// led_chain_frame_buffer_encoder_tb: self-checking bench for the LED encoder
// Drives set, fill and send commands under random idling and backpressure,
// reprograms the palette between quiet phases, predicts every encoded LED
// word and compares each one from the led channel in order.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chain_frame_buffer_encoder_tb;

  localparam int GROUP_A_COUNT = 28;
  localparam int GROUP_B_COUNT = 7;
  localparam int GROUP_C_COUNT = 28;
  localparam int GROUP_D_COUNT = 26;
  localparam int FRAME_DEPTH   = 128;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_MAX    = 10;

  // palette register indexes, the last one lies past the palette
  typedef enum logic [2:0] {
    REG_PAL_RED,
    REG_PAL_ORANGE,
    REG_PAL_YELLOW,
    REG_PAL_GREEN,
    REG_PAL_CYAN,
    REG_PAL_BLUE,
    REG_PAL_PURPLE,
    REG_UNUSED
  } cfg_reg_t;

  typedef enum int {
    PAL_ALL_ONES,
    PAL_ALL_ZERO,
    PAL_RANDOM,
    PAL_STRIPES
  } pal_style_t;

  typedef struct {
    lce_pkg::act_t action;
    logic [2:0]    group;
    logic [5:0]    position;
    logic [7:0]    color_choice;
    logic          chain_select;
  } led_cmd_t;

  typedef struct packed {
    logic        chain_id;
    logic [5:0]  led_number;
    logic [31:0] green_code;
    logic [31:0] red_code;
    logic [31:0] blue_code;
    logic        last_led;
  } led_word_t;

  logic clk;
  logic rst;
  logic calm;
  logic hold_request;

  lce_cmd_if cmd_ch ();
  lce_cfg_if cfg_ch ();
  lce_led_if led_ch ();

  led_chain_frame_buffer_encoder #(
    .GROUP_A_COUNT(GROUP_A_COUNT),
    .GROUP_B_COUNT(GROUP_B_COUNT),
    .GROUP_C_COUNT(GROUP_C_COUNT),
    .GROUP_D_COUNT(GROUP_D_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .cfg(cfg_ch),
    .led(led_ch)
  );

  // number of LEDs in a group, zero for a bad group
  function automatic int group_size(logic [2:0] g);
    case (g)
      lce_pkg::GRP_A: return GROUP_A_COUNT;
      lce_pkg::GRP_B: return GROUP_B_COUNT;
      lce_pkg::GRP_C: return GROUP_C_COUNT;
      lce_pkg::GRP_D: return GROUP_D_COUNT;
      default: return 0;
    endcase
  endfunction

  // frame store mirror, palette mirror and queue of predicted LED words
  class frame_scoreboard;
    logic [23:0] palette [lce_pkg::NUM_PAL];
    logic [23:0] frame [2][FRAME_DEPTH];
    led_word_t   pending_words [$];
    int          errors;

    function new();
      for (int i = 0; i < lce_pkg::NUM_PAL; i++) palette[i] = lce_pkg::PAL_RESET[i];
      for (int c = 0; c < 2; c++)
        for (int i = 0; i < FRAME_DEPTH; i++) frame[c][i] = '0;
      errors = 0;
    endfunction

    function void write_palette(cfg_reg_t idx, logic [23:0] val);
      if (idx < lce_pkg::NUM_PAL) palette[idx] = val;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function logic [23:0] color_for(logic [7:0] choice);
      if (choice == lce_pkg::COLOR_OFF) return '0;
      if (choice < lce_pkg::COLOR_OFF) return palette[choice];
      return palette[REG_PAL_RED];
    endfunction

    // two color bits per serial byte, one nibble per bit, msb first
    function logic [31:0] serial_code(logic [7:0] b);
      logic [31:0] code;
      code = '0;
      for (int i = 7; i >= 0; i--)
        code = {code[27:0], b[i] ? lce_pkg::NIB_ONE : lce_pkg::NIB_ZERO};
      return code;
    endfunction

    function int chain_length(logic ch);
      return ch ? GROUP_C_COUNT + GROUP_D_COUNT : GROUP_A_COUNT + GROUP_B_COUNT;
    endfunction

    function void queue_chain(logic ch);
      int len;
      led_word_t w;
      len = chain_length(ch);
      if (len > lce_pkg::SEND_MAX) len = lce_pkg::SEND_MAX;
      for (int i = 0; i < len; i++) begin
        w.chain_id   = ch;
        w.led_number = i[5:0];
        w.green_code = serial_code(frame[ch][i][23:16]);
        w.red_code   = serial_code(frame[ch][i][15:8]);
        w.blue_code  = serial_code(frame[ch][i][7:0]);
        w.last_led   = (i == len - 1);
        pending_words.push_back(w);
      end
    endfunction

    // update the store for one accepted command and predict its LED words
    function void apply_command(led_cmd_t c);
      logic [23:0] col;
      logic        ch;
      int          base;
      int          cnt;
      col  = color_for(c.color_choice);
      ch   = (c.group == lce_pkg::GRP_C || c.group == lce_pkg::GRP_D);
      base = (c.group == lce_pkg::GRP_B) ? GROUP_A_COUNT :
             (c.group == lce_pkg::GRP_D) ? GROUP_C_COUNT : 0;
      cnt  = group_size(c.group);
      case (c.action)
        lce_pkg::ACT_SET: begin
          if (c.position < cnt) frame[ch][base + c.position] = col;
        end
        lce_pkg::ACT_FILL: begin
          if (cnt > 0) begin
            for (int i = 0; i < cnt; i++) frame[ch][base + i] = col;
            queue_chain(ch);
          end
        end
        lce_pkg::ACT_SEND: queue_chain(c.chain_select);
        default: ;
      endcase
    endfunction

    function void check_led_word(led_word_t got);
      led_word_t exp;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected led word: chain %0d led %0d", got.chain_id, got.led_number);
        return;
      end
      exp = pending_words.pop_front();
      if (got.chain_id !== exp.chain_id || got.led_number !== exp.led_number ||
          got.green_code !== exp.green_code || got.red_code !== exp.red_code ||
          got.blue_code !== exp.blue_code || got.last_led !== exp.last_led) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("led word mismatch: expected chain %0d led %0d g %h r %h b %h last %0d",
                   exp.chain_id, exp.led_number, exp.green_code, exp.red_code,
                   exp.blue_code, exp.last_led);
          $display("                   actual   chain %0d led %0d g %h r %h b %h last %0d",
                   got.chain_id, got.led_number, got.green_code, got.red_code,
                   got.blue_code, got.last_led);
        end
      end
    endfunction
  endclass

  frame_scoreboard sb = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // offer one command, idling first at random, and note it once taken
  task automatic put_cmd(led_cmd_t c);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.action       <= c.action;
    cmd_ch.group        <= c.group;
    cmd_ch.position     <= c.position;
    cmd_ch.color_choice <= c.color_choice;
    cmd_ch.chain_select <= c.chain_select;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.apply_command(c);
  endtask

  task automatic put_cfg(cfg_reg_t idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_palette(idx, val);
  endtask

  // let every predicted word drain and the back end go quiet
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_palette(pal_style_t style);
    logic [23:0] val;
    for (int i = 0; i < lce_pkg::NUM_PAL; i++) begin
      case (style)
        PAL_ALL_ONES: val = 24'hFFFFFF;
        PAL_ALL_ZERO: val = 24'h000000;
        PAL_STRIPES:  val = i[0] ? 24'h555555 : 24'hAAAAAA;
        default:      val = 24'($urandom);
      endcase
      put_cfg(cfg_reg_t'(i), val);
    end
    // a write past the palette must change nothing
    put_cfg(REG_UNUSED, 24'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic led_cmd_t mk_cmd(lce_pkg::act_t a, logic [2:0] g, logic [5:0] p,
                                      logic [7:0] col, logic s);
    led_cmd_t c;
    c.action       = a;
    c.group        = g;
    c.position     = p;
    c.color_choice = col;
    c.chain_select = s;
    return c;
  endfunction

  // mostly valid sets, fills and sends with random content, some noise
  function automatic led_cmd_t random_cmd();
    led_cmd_t   c;
    int         pick;
    logic [2:0] g;
    c.action       = lce_pkg::act_t'($urandom_range(3));
    c.group        = 3'($urandom_range(7));
    c.position     = 6'($urandom_range(63));
    c.color_choice = 8'($urandom_range(255));
    c.chain_select = 1'($urandom_range(1));
    pick = $urandom_range(99);
    g    = 3'($urandom_range(3));
    if (pick >= 10) begin
      if ($urandom_range(3) != 0) c.color_choice = 8'($urandom_range(8));
      if (pick < 50) begin
        c.action   = lce_pkg::ACT_SET;
        c.group    = g;
        c.position = 6'($urandom_range(group_size(g) - 1));
      end else if (pick < 62) begin
        c.action = lce_pkg::ACT_SET;
      end else if (pick < 78) begin
        c.action = lce_pkg::ACT_FILL;
        c.group  = g;
      end else begin
        c.action = lce_pkg::ACT_SEND;
      end
    end
    return c;
  endfunction

  task automatic run_random(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      put_cmd(random_cmd());
    end
  endtask

  // led receiver: random stalls, one long hold-off on request
  initial begin
    int  hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    led_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && led_ch.valid && led_ch.ready)
        sb.check_led_word('{led_ch.chain_id, led_ch.led_number, led_ch.green_code,
                            led_ch.red_code, led_ch.blue_code, led_ch.last_led});
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        led_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 24) begin
        led_ch.ready <= 1'b0;
      end else begin
        led_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    led_cmd_t directed [$];
    calm         = 1'b0;
    hold_request = 1'b0;
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.action       <= lce_pkg::ACT_SET;
    cmd_ch.group        <= lce_pkg::GRP_A;
    cmd_ch.position     <= '0;
    cmd_ch.color_choice <= '0;
    cmd_ch.chain_select <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_PAL_RED;
    cfg_ch.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: both chains off after reset, group edges, bad commands, fills
    directed.push_back(mk_cmd(lce_pkg::ACT_SEND, lce_pkg::GRP_A, 6'd0, 8'd0, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SEND, lce_pkg::GRP_A, 6'd0, 8'd0, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_A, 6'd0, 8'd0, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_A,
                              6'(GROUP_A_COUNT - 1), 8'd6, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_B, 6'd0, 8'd1, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_B,
                              6'(GROUP_B_COUNT - 1), 8'd2, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_C, 6'd0, 8'd3, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_C,
                              6'(GROUP_C_COUNT - 1), 8'd4, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_D, 6'd0, 8'd5, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_D,
                              6'(GROUP_D_COUNT - 1), 8'd8, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_D,
                              6'(GROUP_D_COUNT), 8'd3, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_B, 6'd63, 8'd255, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, 3'd7, 6'd0, 8'd1, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, 3'd4, 6'd1, 8'd2, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_A, 6'd2, 8'd255, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SET, lce_pkg::GRP_A, 6'd0,
                              lce_pkg::COLOR_OFF, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_NONE, lce_pkg::GRP_A, 6'd5, 8'd1, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_SEND, 3'd7, 6'd63, 8'd255, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_SEND, 3'd7, 6'd63, 8'd255, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_FILL, 3'd4, 6'd0, 8'd2, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_FILL, lce_pkg::GRP_B, 6'd0, 8'd255, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_FILL, lce_pkg::GRP_C, 6'd0,
                              lce_pkg::COLOR_OFF, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_FILL, lce_pkg::GRP_A, 6'd0, 8'd6, 1'b1));
    directed.push_back(mk_cmd(lce_pkg::ACT_FILL, lce_pkg::GRP_D, 6'd0, 8'd0, 1'b0));
    directed.push_back(mk_cmd(lce_pkg::ACT_NONE, 3'd7, 6'd63, 8'd255, 1'b1));
    foreach (directed[i]) put_cmd(directed[i]);
    settle();

    // random phases, each under its own palette
    program_palette(PAL_ALL_ONES);
    run_random(100, -1);
    settle();

    // no idling on either side, with one long led hold-off in the middle
    program_palette(PAL_ALL_ZERO);
    calm = 1'b1;
    run_random(100, 30);
    settle();
    calm = 1'b0;

    program_palette(PAL_RANDOM);
    run_random(125, -1);
    settle();

    program_palette(PAL_STRIPES);
    run_random(125, -1);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
